>>> src/tpad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpad_pkg: shared constants and types for the polar angle deviation block
// Widths, the arctangent table and the result beat carried from each angle
// pipeline up to the top level.
// ----------------------------------------------------------------------------
package tpad_pkg;

  localparam int COORD_WIDTH     = 20;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STAGES   = 18;

  // Largest scaled magnitude has exactly this many significant bits
  localparam int NORM_BITS = 30;

  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int EXT_W   = (DIFF_W > NORM_BITS) ? DIFF_W : NORM_BITS;
  localparam int SH_W    = $clog2(EXT_W);
  localparam int SQR_W   = 2 * NORM_BITS;
  localparam int SUM_W   = SQR_W + 1;
  localparam int ROOT_W  = NORM_BITS + 1;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int CORD_W  = ROOT_W + 3;
  localparam int ANG_W   = ANGLE_FRAC_BITS + 3;  // signed angle sum, deviation
  localparam int POL_W   = ANGLE_FRAC_BITS + 2;  // unsigned polar angle

  localparam int Q32_W = 34;

  // atan(2^-i), 32 fractional bits
  localparam logic [Q32_W-1:0] ATAN_Q32 [32] = '{
    34'd3373259426, 34'd1991351318, 34'd1052175346, 34'd534100635,
    34'd268086748,  34'd134174063,  34'd67103403,   34'd33553749,
    34'd16777131,   34'd8388597,    34'd4194303,    34'd2097152,
    34'd1048576,    34'd524288,     34'd262144,     34'd131072,
    34'd65536,      34'd32768,      34'd16384,      34'd8192,
    34'd4096,       34'd2048,       34'd1024,       34'd512,
    34'd256,        34'd128,        34'd64,         34'd32,
    34'd16,         34'd8,          34'd4,          34'd2
  };

  localparam logic [Q32_W-1:0] PI_Q32      = 34'd13493037705;
  localparam logic [Q32_W-1:0] HALF_PI_Q32 = 34'd6746518852;

  // Round half up from 32 fractional bits to ANGLE_FRAC_BITS
  function automatic logic [ANG_W-1:0] round_q32(logic [Q32_W-1:0] v);
    logic [Q32_W-1:0] r;
    r = (v + (Q32_W'(1) << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS);
    return r[ANG_W-1:0];
  endfunction

  localparam logic [ANG_W-1:0] PI_FIX      = round_q32(PI_Q32);
  localparam logic [ANG_W-1:0] HALF_PI_FIX = round_q32(HALF_PI_Q32);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;
  } track_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [POL_W-1:0] angle;
  } pol_res_t;

endpackage

>>> src/tpad_polar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpad_polar: pipelined polar angle of one track direction
// Difference, normalize, rho = isqrt(dx^2+dy^2) one bit per stage, then a
// vectoring CORDIC one iteration per stage and the final clamp/fold.
// ----------------------------------------------------------------------------
module tpad_polar (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tpad_pkg::track_t  in_trk,
  output tpad_pkg::pol_res_t out_res
);

  localparam int NB  = tpad_pkg::NORM_BITS;
  localparam int DW  = tpad_pkg::DIFF_W;
  localparam int RW  = tpad_pkg::ROOT_W;
  localparam int CS  = tpad_pkg::CORDIC_STAGES;
  localparam int CW  = tpad_pkg::CORD_W;
  localparam int AW  = tpad_pkg::ANG_W;
  localparam int QW  = tpad_pkg::REM_W;

  typedef struct packed {
    logic          zero;
    logic          up;
    logic [NB-1:0] az;
  } side_t;

  // ---- stage 1: direction ----
  logic                 v1_r;
  logic signed [DW-1:0] dx_r, dy_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    dx_r <= DW'(in_trk.end_x) - DW'(in_trk.start_x);
    dy_r <= DW'(in_trk.end_y) - DW'(in_trk.start_y);
    dz_r <= DW'(in_trk.end_z) - DW'(in_trk.start_z);
  end

  // ---- stage 2: magnitudes ----
  logic          v2_r, zero2_r, up2_r;
  logic [DW-1:0] ax2_r, ay2_r, az2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    ax2_r   <= dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
    ay2_r   <= dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
    az2_r   <= dz_r[DW-1] ? DW'(-dz_r) : DW'(dz_r);
    zero2_r <= (dx_r == '0) && (dy_r == '0) && (dz_r == '0);
    up2_r   <= !dz_r[DW-1] && (dz_r != '0);
  end

  // ---- stage 3: leading one of the largest magnitude ----
  logic [DW-1:0]                 mx;
  logic [tpad_pkg::SH_W-1:0]     msb, lsh_nxt, rsh_nxt;
  logic                          v3_r, zero3_r, up3_r;
  logic [DW-1:0]                 ax3_r, ay3_r, az3_r;
  logic [tpad_pkg::SH_W-1:0]     lsh_r, rsh_r;

  always_comb begin
    int len;
    mx = ax2_r;
    if (ay2_r > mx) mx = ay2_r;
    if (az2_r > mx) mx = az2_r;
    msb = '0;
    for (int i = 0; i < DW; i++) begin
      if (mx[i]) msb = tpad_pkg::SH_W'(i);
    end
    len = int'(msb) + 1;
    if (len > NB) begin
      rsh_nxt = tpad_pkg::SH_W'(len - NB);
      lsh_nxt = '0;
    end else begin
      rsh_nxt = '0;
      lsh_nxt = tpad_pkg::SH_W'(NB - len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    ax3_r   <= ax2_r;
    ay3_r   <= ay2_r;
    az3_r   <= az2_r;
    zero3_r <= zero2_r;
    up3_r   <= up2_r;
    lsh_r   <= lsh_nxt;
    rsh_r   <= rsh_nxt;
  end

  // ---- stage 4: scale ----
  logic [tpad_pkg::EXT_W-1:0] sx_ext, sy_ext, sz_ext;
  logic                       v4_r, zero4_r, up4_r;
  logic [NB-1:0]              ax4_r, ay4_r, az4_r;

  always_comb begin
    sx_ext = (tpad_pkg::EXT_W'(ax3_r) << lsh_r) >> rsh_r;
    sy_ext = (tpad_pkg::EXT_W'(ay3_r) << lsh_r) >> rsh_r;
    sz_ext = (tpad_pkg::EXT_W'(az3_r) << lsh_r) >> rsh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    ax4_r   <= sx_ext[NB-1:0];
    ay4_r   <= sy_ext[NB-1:0];
    az4_r   <= sz_ext[NB-1:0];
    zero4_r <= zero3_r;
    up4_r   <= up3_r;
  end

  // ---- stage 5: squares ----
  logic                          v5_r;
  logic [tpad_pkg::SQR_W-1:0]    sqx_r, sqy_r;
  side_t                         side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    sqx_r   <= ax4_r * ax4_r;
    sqy_r   <= ay4_r * ay4_r;
    side5_r <= '{zero: zero4_r, up: up4_r, az: az4_r};
  end

  // ---- stage 6: radicand, then one root bit per stage ----
  logic                          sq_v_r    [RW+1];
  side_t                         sq_side_r [RW+1];
  logic [tpad_pkg::RAD_W-1:0]    sq_rad_r  [RW+1];
  logic [QW-1:0]                 sq_rem_r  [RW+1];
  logic [RW-1:0]                 sq_root_r [RW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= v5_r;
    end
    sq_rad_r[0]  <= tpad_pkg::RAD_W'(tpad_pkg::SUM_W'(sqx_r) + tpad_pkg::SUM_W'(sqy_r));
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_side_r[0] <= side5_r;
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [QW-1:0] rem_sh, trial, rem_nxt;
    logic [RW-1:0] root_nxt;

    always_comb begin
      rem_sh = {sq_rem_r[k][QW-3:0], sq_rad_r[k][tpad_pkg::RAD_W-1 -: 2]};
      trial  = {1'b0, sq_root_r[k], 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {sq_root_r[k][RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {sq_root_r[k][RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
      sq_rad_r[k+1]  <= sq_rad_r[k] << 2;
      sq_rem_r[k+1]  <= rem_nxt;
      sq_root_r[k+1] <= root_nxt;
      sq_side_r[k+1] <= sq_side_r[k];
    end
  end

  // ---- CORDIC, vectoring, one iteration per stage ----
  logic                 c_v_r    [CS];
  side_t                c_side_r [CS];
  logic signed [CW-1:0] c_x_r    [CS];
  logic signed [CW-1:0] c_y_r    [CS];
  logic signed [AW-1:0] c_acc_r  [CS];

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    localparam logic signed [AW-1:0] STEP_ANG =
      signed'(tpad_pkg::round_q32(tpad_pkg::ATAN_Q32[i]));

    logic                 v_in;
    side_t                side_in;
    logic signed [CW-1:0] x_in, y_in, xs, ys;
    logic signed [AW-1:0] acc_in;

    if (i == 0) begin : g_first
      assign v_in    = sq_v_r[RW];
      assign side_in = sq_side_r[RW];
      assign x_in    = signed'({{(CW-NB){1'b0}}, sq_side_r[RW].az});
      assign y_in    = signed'({{(CW-RW){1'b0}}, sq_root_r[RW]});
      assign acc_in  = '0;
    end else begin : g_next
      assign v_in    = c_v_r[i-1];
      assign side_in = c_side_r[i-1];
      assign x_in    = c_x_r[i-1];
      assign y_in    = c_y_r[i-1];
      assign acc_in  = c_acc_r[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_v_r[i] <= 1'b0;
      end else begin
        c_v_r[i] <= v_in;
      end
      c_side_r[i] <= side_in;
      if (!y_in[CW-1]) begin
        c_x_r[i]   <= x_in + ys;
        c_y_r[i]   <= y_in - xs;
        c_acc_r[i] <= acc_in + STEP_ANG;
      end else begin
        c_x_r[i]   <= x_in - ys;
        c_y_r[i]   <= y_in + xs;
        c_acc_r[i] <= acc_in - STEP_ANG;
      end
    end
  end

  // ---- clamp to [0, pi/2], fold upward directions ----
  logic signed [AW-1:0] acc_last;
  logic [AW-1:0]        clamped, polar;
  side_t                side_last;
  tpad_pkg::pol_res_t   res_r;

  assign acc_last  = c_acc_r[CS-1];
  assign side_last = c_side_r[CS-1];

  always_comb begin
    if (acc_last[AW-1]) begin
      clamped = '0;
    end else if (AW'(acc_last) > tpad_pkg::HALF_PI_FIX) begin
      clamped = tpad_pkg::HALF_PI_FIX;
    end else begin
      clamped = AW'(acc_last);
    end
    if (side_last.zero) begin
      polar = '0;
    end else if (side_last.up) begin
      polar = tpad_pkg::PI_FIX - clamped;
    end else begin
      polar = clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= c_v_r[CS-1];
    end
    res_r.zero  <= side_last.zero;
    res_r.angle <= polar[tpad_pkg::POL_W-1:0];
  end

  assign out_res = res_r;

endmodule

>>> src/track_polar_angle_deviation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_polar_angle_deviation: polar angle change between two tracks
// Outgoing minus incoming polar angle from the downward axis, Q16 radians.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: raise start with the first/last hit points of the incoming
//   track (in_start_*, in_end_*) and the outgoing track (in_out_start_*,
//   in_out_end_*), signed, 4 fractional bits. A beat is taken on every edge
//   where start is high and busy is low; busy is held low, so a new pair
//   can enter every cycle.
//   Result beat: out_valid is high for one cycle with out_deviation (signed,
//   16 fractional bits) and out_degenerate (a direction had zero length,
//   its angle counts as 0). Results leave in input order.
//   Each of the two identical angle pipelines computes one root bit per
//   stage and one CORDIC iteration per stage; an output register follows
//   them. Throughput is one pair per cycle.
//   Reset (rst_n low, synchronous) clears all valid bits; data in flight is
//   dropped. The receiver has no back-pressure: every out_valid cycle is
//   taken, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module track_polar_angle_deviation (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [tpad_pkg::COORD_WIDTH-1:0]  in_start_x,
  input  logic signed [tpad_pkg::COORD_WIDTH-1:0]  in_start_y,
  input  logic signed [tpad_pkg::COORD_WIDTH-1:0]  in_start_z,
  input  logic signed [tpad_pkg::COORD_WIDTH-1:0]  in_end_x,
  input  logic signed [tpad_pkg::COORD_WIDTH-1:0]  in_end_y,
  input  logic signed [tpad_pkg::COORD_WIDTH-1:0]  in_end_z,
  input  logic signed [tpad_pkg::COORD_WIDTH-1:0]  in_out_start_x,
  input  logic signed [tpad_pkg::COORD_WIDTH-1:0]  in_out_start_y,
  input  logic signed [tpad_pkg::COORD_WIDTH-1:0]  in_out_start_z,
  input  logic signed [tpad_pkg::COORD_WIDTH-1:0]  in_out_end_x,
  input  logic signed [tpad_pkg::COORD_WIDTH-1:0]  in_out_end_y,
  input  logic signed [tpad_pkg::COORD_WIDTH-1:0]  in_out_end_z,
  output logic                                     out_valid,
  output logic signed [tpad_pkg::ANG_W-1:0]        out_deviation,
  output logic                                     out_degenerate
);

  logic               accept;
  tpad_pkg::track_t   trk_in, trk_out;
  tpad_pkg::pol_res_t res_in, res_out;

  // Pipeline advances every cycle; nothing ever holds it off.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign trk_in = '{start_x: in_start_x, start_y: in_start_y, start_z: in_start_z,
                    end_x: in_end_x, end_y: in_end_y, end_z: in_end_z};

  assign trk_out = '{start_x: in_out_start_x, start_y: in_out_start_y,
                     start_z: in_out_start_z, end_x: in_out_end_x,
                     end_y: in_out_end_y, end_z: in_out_end_z};

  // Two identical lanes, fed in lockstep
  tpad_polar u_polar_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_trk   (trk_in),
    .out_res  (res_in)
  );

  tpad_polar u_polar_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_trk   (trk_out),
    .out_res  (res_out)
  );

  // Output register: deviation and the degenerate flag
  logic                              out_valid_r;
  logic signed [tpad_pkg::ANG_W-1:0] out_deviation_r;
  logic                              out_degenerate_r;
  logic signed [tpad_pkg::ANG_W-1:0] dev_nxt;

  // Both angles in [0, pi], so the difference fits ANG_W signed bits
  assign dev_nxt = signed'(tpad_pkg::ANG_W'(res_out.angle))
                 - signed'(tpad_pkg::ANG_W'(res_in.angle));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_in.valid && res_out.valid;
    end
    out_deviation_r  <= dev_nxt;
    out_degenerate_r <= res_in.zero || res_out.zero;
  end

  assign out_valid      = out_valid_r;
  assign out_deviation  = out_deviation_r;
  assign out_degenerate = out_degenerate_r;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the track polar angle deviation block
// Drives pairs of tracks (first and last hit of the incoming and the outgoing
// track) and checks every result beat against a bit-exact angle predictor:
// normalize, integer root, fixed-point CORDIC, clamp, fold for upward tracks.
// A directed set covers the corner cases, then random pairs follow.
// ----------------------------------------------------------------------------
module tb_top;

  typedef tpad_pkg::track_t track_t;

  typedef logic signed [tpad_pkg::COORD_WIDTH-1:0] coord_t;
  typedef logic [tpad_pkg::ANG_W-1:0] dev_t;

  localparam coord_t CMIN = coord_t'(-524288);
  localparam coord_t CMAX = coord_t'(524287);

  // Predictor constants, angles in Q32 radians
  localparam int NUM_STAGES = 18;
  localparam int SCALE_BITS = 30;
  localparam longint PI_Q32_C = 64'd13493037705;
  localparam longint HALF_PI_Q32_C = 64'd6746518852;
  localparam longint ATAN_Q32_TAB [0:NUM_STAGES-1] = '{
    64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635,
    64'd268086748,  64'd134174063,  64'd67103403,   64'd33553749,
    64'd16777131,   64'd8388597,    64'd4194303,    64'd2097152,
    64'd1048576,    64'd524288,     64'd262144,     64'd131072,
    64'd65536,      64'd32768
  };

  // Extra drain after the last predicted result, to watch for stray beats
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PAIRS = 750;
  // No sender idling over the last stretch of the random part, so beats there are back-to-back
  localparam int STEADY_TAIL = 150;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the deviation of each accepted pair and holds the
  // predictions until the matching result beat comes out
  // --------------------------------------------------------------------------
  class dev_scoreboard;
    typedef struct {
      int   idx;
      dev_t dev;
      logic degen;
    } dev_pred_t;

    dev_pred_t pending_q[$];
    int errors;
    int pairs_in;
    int results_ok;
    int degen_pairs;
    int flat_pairs;

    function automatic longint q32_to_q16(longint v);
      return (v + 64'd32768) >>> 16;
    endfunction

    // Polar angle from the downward axis, Q16 radians, in [0, pi]
    function automatic longint polar_q16(longint dx, longint dy, longint dz,
                                         ref bit zero);
      logic [63:0] ax, ay, az, top, sq, rem, root, bitv;
      longint x, y, xs, ys, acc;
      int len;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      az = (dz < 0) ? -dz : dz;
      top = ax;
      if (ay > top) top = ay;
      if (az > top) top = az;
      if (top == 0) begin
        zero = 1'b1;
        return 0;
      end
      len = 0;
      while (len < 64 && (top >> len) != 0) len++;
      // Scale so the largest magnitude has exactly SCALE_BITS bits
      if (len > SCALE_BITS) begin
        ax = ax >> (len - SCALE_BITS);
        ay = ay >> (len - SCALE_BITS);
        az = az >> (len - SCALE_BITS);
      end else begin
        ax = ax << (SCALE_BITS - len);
        ay = ay << (SCALE_BITS - len);
        az = az << (SCALE_BITS - len);
      end
      // floor(sqrt(ax^2 + ay^2)), bit by bit
      sq = ax * ax + ay * ay;
      rem = sq;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      // Vectoring CORDIC, arithmetic shifts round toward minus infinity
      x = az;
      y = root;
      acc = 0;
      for (int i = 0; i < NUM_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          acc = acc + q32_to_q16(ATAN_Q32_TAB[i]);
        end else begin
          x = x - ys;
          y = y + xs;
          acc = acc - q32_to_q16(ATAN_Q32_TAB[i]);
        end
      end
      if (acc < 0) acc = 0;
      if (acc > q32_to_q16(HALF_PI_Q32_C)) acc = q32_to_q16(HALF_PI_Q32_C);
      // Pointing up: measure from the other end
      if (dz > 0) acc = q32_to_q16(PI_Q32_C) - acc;
      return acc;
    endfunction

    function automatic void note_pair(track_t a, track_t b);
      dev_pred_t p;
      bit zero;
      longint ang_a, ang_b, adz, bdz;
      zero = 1'b0;
      adz = longint'(a.end_z) - longint'(a.start_z);
      bdz = longint'(b.end_z) - longint'(b.start_z);
      ang_a = polar_q16(longint'(a.end_x) - longint'(a.start_x),
                        longint'(a.end_y) - longint'(a.start_y), adz, zero);
      ang_b = polar_q16(longint'(b.end_x) - longint'(b.start_x),
                        longint'(b.end_y) - longint'(b.start_y), bdz, zero);
      p.idx = pairs_in;
      p.dev = dev_t'(ang_b - ang_a);
      p.degen = zero;
      pending_q.insert(pending_q.size(), p);
      pairs_in++;
      if (zero) degen_pairs++;
      if (adz == 0 || bdz == 0) flat_pairs++;
    endfunction

    task automatic report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task automatic check_result(dev_t dev, logic degen);
      dev_pred_t p;
      bit good;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending (dev %h)",
                                  dev));
        return;
      end
      p = pending_q.pop_front();
      good = 1'b1;
      if (dev !== p.dev) begin
        good = 1'b0;
        report_mismatch($sformatf("pair %0d: deviation %h, predicted %h",
                                  p.idx, dev, p.dev));
      end
      if (degen !== p.degen) begin
        good = 1'b0;
        report_mismatch($sformatf("pair %0d: degenerate %b, predicted %b",
                                  p.idx, degen, p.degen));
      end
      if (good) results_ok++;
    endtask

    function automatic int pending();
      return pending_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic out_valid;
  dev_t out_deviation;
  logic out_degenerate;

  // Incoming and outgoing track currently on the input ports
  track_t inc_trk = '0;
  track_t out_trk = '0;

  dev_scoreboard sb;
  int cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  track_polar_angle_deviation DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_start_x     (inc_trk.start_x),
    .in_start_y     (inc_trk.start_y),
    .in_start_z     (inc_trk.start_z),
    .in_end_x       (inc_trk.end_x),
    .in_end_y       (inc_trk.end_y),
    .in_end_z       (inc_trk.end_z),
    .in_out_start_x (out_trk.start_x),
    .in_out_start_y (out_trk.start_y),
    .in_out_start_z (out_trk.start_z),
    .in_out_end_x   (out_trk.end_x),
    .in_out_end_y   (out_trk.end_y),
    .in_out_end_z   (out_trk.end_z),
    .out_valid      (out_valid),
    .out_deviation  (out_deviation),
    .out_degenerate (out_degenerate)
  );

  // One monitor for both channels, so checking and noting never race on the
  // queue; results are checked before the beat of the same edge is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_deviation, out_degenerate);
      if (start && !busy) sb.note_pair(inc_trk, out_trk);
    end
  end

  // Watchdog: ample for the slowest legal run (every beat after the longest
  // idle gap, plus pipeline depth and drain)
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending());
      $display("[track_polar_angle_deviation] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic track_t mk_track(int sx, int sy, int sz,
                                      int ex, int ey, int ez);
    track_t t;
    t.start_x = coord_t'(sx);
    t.start_y = coord_t'(sy);
    t.start_z = coord_t'(sz);
    t.end_x = coord_t'(ex);
    t.end_y = coord_t'(ey);
    t.end_z = coord_t'(ez);
    return t;
  endfunction

  function automatic coord_t rnd_coord();
    return coord_t'($urandom);
  endfunction

  // Small step from a point; wraps at the field width like the port does
  function automatic coord_t rnd_near(coord_t base, int k);
    int d;
    d = int'($urandom_range(0, 2 << k)) - (1 << k);
    return coord_t'(int'(base) + d);
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return CMIN;
      1: return CMAX;
      2: return coord_t'(0);
      3: return coord_t'(-1);
      default: return rnd_coord();
    endcase
  endfunction

  // One random track; the mix leans on realistic short tracks and full-range
  // noise, with zero-length, horizontal, axis-aligned and extreme cases
  function automatic track_t rnd_track();
    track_t t;
    int r, k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 12);
    t.start_x = rnd_coord();
    t.start_y = rnd_coord();
    t.start_z = rnd_coord();
    t.end_x = rnd_coord();
    t.end_y = rnd_coord();
    t.end_z = rnd_coord();
    if (r < 35) begin
      // fully random, already set
    end else if (r < 65) begin
      t.end_x = rnd_near(t.start_x, k);
      t.end_y = rnd_near(t.start_y, k);
      t.end_z = rnd_near(t.start_z, k);
    end else if (r < 70) begin
      t.end_x = t.start_x;
      t.end_y = t.start_y;
      t.end_z = t.start_z;
    end else if (r < 80) begin
      t.end_z = t.start_z;
      if ($urandom_range(0, 1)) begin
        t.end_x = rnd_near(t.start_x, k);
        t.end_y = rnd_near(t.start_y, k);
      end
    end else if (r < 90) begin
      t.end_x = t.start_x;
      t.end_y = t.start_y;
      t.end_z = t.start_z;
      case ($urandom_range(0, 2))
        0: t.end_x = rnd_coord();
        1: t.end_y = rnd_coord();
        default: t.end_z = rnd_coord();
      endcase
    end else begin
      t.start_x = pick_extreme();
      t.start_y = pick_extreme();
      t.start_z = pick_extreme();
      t.end_x = pick_extreme();
      t.end_y = pick_extreme();
      t.end_z = pick_extreme();
    end
    return t;
  endfunction

  // Present one pair and hold it until a beat is taken; start stays high so
  // a following call gives back-to-back beats
  task automatic send_pair(track_t a, track_t b);
    @(negedge clk);
    inc_trk = a;
    out_trk = b;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    track_t down, up;
    sb = new();
    down = mk_track(0, 0, 0, 0, 0, -16);
    up = mk_track(0, 0, 0, 0, 0, 16);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero-length tracks on either or both sides
    send_pair(mk_track(0, 0, 0, 0, 0, 0), mk_track(0, 0, 0, 0, 0, 0));
    send_pair(mk_track(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), down);
    send_pair(down, mk_track(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    // Straight down vs straight up: deviation of +pi and -pi
    send_pair(down, up);
    send_pair(up, down);
    // Horizontal tracks (dz = 0)
    send_pair(mk_track(0, 0, 5, 100, 0, 5), mk_track(7, -3, -9, 7, 900, -9));
    send_pair(mk_track(CMIN, 0, 0, CMAX, 0, 0), up);
    // Widest spans, every difference at its extreme
    send_pair(mk_track(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN),
              mk_track(CMAX, CMAX, CMIN, CMIN, CMIN, CMAX));
    send_pair(mk_track(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN),
              mk_track(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    // One-unit steps, smallest nonzero directions
    send_pair(mk_track(0, 0, 0, 1, 0, -1), mk_track(0, 0, 0, 0, -1, 1));
    send_pair(mk_track(-1, -1, -1, -1, -1, 0), mk_track(3, 3, 3, 3, 3, 2));
    // Nearly vertical over full height, nearly horizontal over full width
    send_pair(mk_track(0, 0, CMAX, 1, 0, CMIN), mk_track(0, 0, CMIN, 0, 1, CMAX));
    send_pair(mk_track(CMIN, 0, 0, CMAX, 0, 1), mk_track(0, CMAX, 0, 0, CMIN, -1));
    // 45 degrees either way, then two tracks that meet at a common hit point
    send_pair(mk_track(0, 0, 0, 4096, 0, -4096), mk_track(0, 0, 0, 0, 4096, 4096));
    send_pair(mk_track(12, -40, 300, -1000, 2000, -5000),
              mk_track(-1000, 2000, -5000, -900, 2100, -9000));
    idle_for(3);

    // Random pairs, bursts of sender idling except over the last stretch
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      send_pair(rnd_track(), rnd_track());
      if (i < RANDOM_PAIRS - STEADY_TAIL && $urandom_range(0, 3) == 0)
        idle_for($urandom_range(1, 15));
    end
    idle_for(1);

    // Drain: everything predicted must come out, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d track pairs, %0d results matched; %0d had a zero-length",
             sb.pairs_in, sb.results_ok, sb.degen_pairs);
    $display("track and %0d a horizontal one; %0d mismatches.",
             sb.flat_pairs, sb.errors);
    if (sb.errors == 0) begin
      $display("[track_polar_angle_deviation] OK");
    end else begin
      $display("[track_polar_angle_deviation] ERROR");
    end
    $finish;
  end

endmodule
